// ===== design/uart_screen_line_mirror_assert.svh =====
// ----------------------------------------------------------------------------
// uart_screen_line_mirror_assert.svh
// Assertion macros shared by the line mirror RTL.
// ----------------------------------------------------------------------------
`ifndef UART_SCREEN_LINE_MIRROR_ASSERT_SVH
`define UART_SCREEN_LINE_MIRROR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define USLM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uslm: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define USLM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uslm: next-cycle check failed");

`endif

// ===== design/uslm_pkg.sv =====
// ----------------------------------------------------------------------------
// uslm_pkg
// Item codes and fixed character constants for the serial line mirror.
// ----------------------------------------------------------------------------
package uslm_pkg;

  // Item opcodes carried on the mode field
  typedef enum logic [1:0] {
    MODE_TX_TICK = 2'd0,
    MODE_RX_TICK = 2'd1,
    MODE_WRITE   = 2'd2,
    MODE_READ    = 2'd3
  } mode_t;

  // Fixed cells of the line image
  localparam logic [7:0] CHAR_HT    = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Shift pattern of a filler frame: line stays high
  localparam logic [7:0] BYTE_IDLE = 8'hFF;

  // Frame layout in bit slots: start in slot 0, data 1..8, stop 9..10, idle 11
  localparam logic [3:0] SLOT_START     = 4'd0;
  localparam logic [3:0] SLOT_FIRST     = 4'd1;
  localparam logic [3:0] SLOT_DATA_LAST = 4'd8;
  localparam logic [3:0] SLOT_STOP_LAST = 4'd10;

  // Data bits in one received frame
  localparam logic [3:0] RX_DATA_BITS = 4'd8;

endpackage

// ===== design/uart_screen_line_mirror.sv =====
// ----------------------------------------------------------------------------
// uart_screen_line_mirror
// Serial mirror of a two-row text display with a receive path.
//
// Usage: one item on the in channel (valid/ready) per tick or command; mode
// selects a transmit tick, a receive sample tick, a character write or a
// read of the last received byte. Every item gives exactly one result on the
// out channel: tx_line (transmit level after the item) and rx_char.
// An item accepted at an edge shows its result from that edge on. Throughput
// is one item per cycle while the receiver keeps up; the line image is a
// 37-entry memory whose registered read port always tracks the current byte
// slot, with a write bypass, so a start bit never waits on the memory.
// If the receiver stalls, the result holds in the output register and
// in_ready drops until that register is emptied or being emptied.
// Reset clears all control state, sets tx_line idle high and marks every
// image cell as unwritten; unwritten cells read as their power-up text
// (zeros, tab, two spaces, CR, LF). No clearing pass is needed.
// ----------------------------------------------------------------------------
module uart_screen_line_mirror #(
  parameter int ROW_CHARS   = 16,
  parameter int IMAGE_BYTES = 37,
  parameter int LAST_SLOT   = 137
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic       rx_bit,
  input  logic       text_line,
  input  logic [3:0] text_column,
  input  logic [7:0] text_char,
  input  logic       text_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       tx_line,
  output logic [7:0] rx_char
);

  `include "uart_screen_line_mirror_assert.svh"

  localparam int AW = $clog2(IMAGE_BYTES);
  localparam bit HAS_TAB = ROW_CHARS < IMAGE_BYTES;
  localparam logic [7:0] IMAGE_END  = 8'(IMAGE_BYTES);
  localparam logic [7:0] SLOT_WRAP  = 8'(LAST_SLOT);
  localparam logic [7:0] ROW_LEN    = 8'(ROW_CHARS);
  localparam logic [AW-1:0] RX_CELL = AW'(IMAGE_BYTES - 3);

  typedef enum logic [1:0] {
    RX_WAIT  = 2'd0,
    RX_DATA  = 2'd1,
    RX_STOP  = 2'd2,
    RX_SPARE = 2'd3
  } rx_phase_t;

  // Power-up content of one image cell; later cells take priority as in
  // the layout order (tab, then the trailer).
  function automatic logic [7:0] image_init(input logic [AW-1:0] a);
    logic [7:0] v;
    v = 8'd0;
    if (HAS_TAB && (a == AW'(ROW_CHARS))) v = uslm_pkg::CHAR_HT;
    if (a == AW'(IMAGE_BYTES - 4)) v = uslm_pkg::CHAR_SPACE;
    if (a == AW'(IMAGE_BYTES - 3)) v = uslm_pkg::CHAR_SPACE;
    if (a == AW'(IMAGE_BYTES - 2)) v = uslm_pkg::CHAR_CR;
    if (a == AW'(IMAGE_BYTES - 1)) v = uslm_pkg::CHAR_LF;
    return v;
  endfunction

  // Control state
  logic            resend_pending, resend_pending_next;
  logic [3:0]      tx_bit_slot, tx_bit_slot_next;
  logic [7:0]      tx_byte_slot, tx_byte_slot_next;
  logic [7:0]      tx_shift, tx_shift_next;
  logic            tx_level, tx_level_next;
  rx_phase_t       rx_phase, rx_phase_next;
  logic [7:0]      rx_shift, rx_shift_next;
  logic [3:0]      rx_bit_count, rx_bit_count_next;
  logic [7:0]      rx_held, rx_held_next;
  logic [7:0]      rx_char_next;

  // Line image memory with per-cell written flags
  logic [7:0]             image_mem [IMAGE_BYTES];
  logic [IMAGE_BYTES-1:0] image_written;
  logic [7:0]             rd_data;
  logic                   rd_written;

  logic            accept;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;
  logic [7:0]      rd_slot;
  logic            rd_in_range;
  logic [AW-1:0]   rd_addr;
  logic            slot_in_range;
  logic [7:0]      image_byte;
  logic [7:0]      byte_inc;
  logic [7:0]      wr_pos_raw;
  logic [7:0]      wr_pos;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Byte that the current slot would start sending
  assign slot_in_range = tx_byte_slot < IMAGE_END;
  assign image_byte    = rd_written ? rd_data : image_init(tx_byte_slot[AW-1:0]);
  assign byte_inc      = tx_byte_slot + 8'd1;

  // Text cell of a write; the tab cell is skipped
  assign wr_pos_raw = text_line ? (ROW_LEN + {4'd0, text_column}) : {4'd0, text_column};
  assign wr_pos     = (wr_pos_raw >= ROW_LEN) ? (wr_pos_raw + 8'd1) : wr_pos_raw;

  always_comb begin
    resend_pending_next = resend_pending;
    tx_bit_slot_next    = tx_bit_slot;
    tx_byte_slot_next   = tx_byte_slot;
    tx_shift_next       = tx_shift;
    tx_level_next       = tx_level;
    rx_phase_next       = rx_phase;
    rx_shift_next       = rx_shift;
    rx_bit_count_next   = rx_bit_count;
    rx_held_next        = rx_held;
    rx_char_next        = 8'd0;
    mem_we              = 1'b0;
    mem_waddr           = wr_pos[AW-1:0];
    mem_wdata           = text_char;
    if (accept) begin
      case (uslm_pkg::mode_t'(mode))
        uslm_pkg::MODE_TX_TICK: begin
          if (tx_bit_slot == uslm_pkg::SLOT_START) begin
            // Hold idle unless a resend is pending
            if (resend_pending) begin
              if (slot_in_range) begin
                tx_level_next = 1'b0;
                tx_shift_next = image_byte;
              end else begin
                tx_shift_next = uslm_pkg::BYTE_IDLE;
              end
              tx_bit_slot_next = uslm_pkg::SLOT_FIRST;
            end
          end else if (tx_bit_slot <= uslm_pkg::SLOT_DATA_LAST) begin
            tx_level_next    = tx_shift[0];
            tx_shift_next    = {1'b0, tx_shift[7:1]};
            tx_bit_slot_next = tx_bit_slot + 4'd1;
          end else if (tx_bit_slot <= uslm_pkg::SLOT_STOP_LAST) begin
            tx_level_next    = 1'b1;
            tx_bit_slot_next = tx_bit_slot + 4'd1;
          end else begin
            // Idle tick ends the frame: advance the byte slot
            tx_bit_slot_next  = uslm_pkg::SLOT_START;
            tx_byte_slot_next = byte_inc;
            if (byte_inc == IMAGE_END) begin
              resend_pending_next = 1'b0;
            end else if (byte_inc > SLOT_WRAP) begin
              tx_byte_slot_next = 8'd0;
            end
          end
        end
        uslm_pkg::MODE_RX_TICK: begin
          case (rx_phase)
            RX_WAIT: begin
              if (!rx_bit) begin
                rx_bit_count_next = 4'd0;
                rx_phase_next     = RX_DATA;
              end
            end
            RX_DATA: begin
              rx_shift_next     = {rx_bit, rx_shift[7:1]};
              rx_bit_count_next = rx_bit_count + 4'd1;
              if (rx_bit_count_next == uslm_pkg::RX_DATA_BITS) rx_phase_next = RX_STOP;
            end
            RX_STOP: begin
              // Good stop bit: keep the byte and mirror it into the image
              if (rx_bit) begin
                rx_held_next        = rx_shift;
                resend_pending_next = 1'b1;
                mem_we              = 1'b1;
                mem_waddr           = RX_CELL;
                mem_wdata           = rx_shift;
              end
              rx_phase_next = RX_WAIT;
            end
            default: begin
              rx_phase_next = RX_WAIT;
            end
          endcase
        end
        uslm_pkg::MODE_WRITE: begin
          if (wr_pos < IMAGE_END) mem_we = 1'b1;
          if (text_last) resend_pending_next = 1'b1;
        end
        uslm_pkg::MODE_READ: begin
          rx_char_next = rx_held;
          rx_held_next = 8'd0;
        end
        default: begin
          rx_char_next = 8'd0;
        end
      endcase
    end
  end

  // Read port follows the byte slot that will be current after this edge
  assign rd_slot     = accept ? tx_byte_slot_next : tx_byte_slot;
  assign rd_in_range = rd_slot < IMAGE_END;
  assign rd_addr     = rd_in_range ? rd_slot[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we) image_mem[mem_waddr] <= mem_wdata;
    if (mem_we && (mem_waddr == rd_addr)) begin
      rd_data <= mem_wdata;
    end else begin
      rd_data <= image_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_written <= '0;
      rd_written    <= 1'b0;
    end else begin
      if (mem_we) image_written[mem_waddr] <= 1'b1;
      rd_written <= (mem_we && (mem_waddr == rd_addr)) || image_written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resend_pending <= 1'b0;
      tx_bit_slot    <= uslm_pkg::SLOT_START;
      tx_byte_slot   <= 8'd0;
      tx_shift       <= 8'd0;
      tx_level       <= 1'b1;
      rx_phase       <= RX_WAIT;
      rx_shift       <= 8'd0;
      rx_bit_count   <= 4'd0;
      rx_held        <= 8'd0;
      out_valid      <= 1'b0;
      tx_line        <= 1'b1;
      rx_char        <= 8'd0;
    end else begin
      resend_pending <= resend_pending_next;
      tx_bit_slot    <= tx_bit_slot_next;
      tx_byte_slot   <= tx_byte_slot_next;
      tx_shift       <= tx_shift_next;
      tx_level       <= tx_level_next;
      rx_phase       <= rx_phase_next;
      rx_shift       <= rx_shift_next;
      rx_bit_count   <= rx_bit_count_next;
      rx_held        <= rx_held_next;
      if (accept) begin
        out_valid <= 1'b1;
        tx_line   <= tx_level_next;
        rx_char   <= rx_char_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A read always drains the held byte
  `USLM_ASSERT_NEXT(a_read_clears, accept && (mode == uslm_pkg::MODE_READ), rx_held == 8'd0)
  // Stop bits and the idle tick keep the line high
  `USLM_ASSERT_NOW(a_stop_high, tx_bit_slot >= 4'd10, tx_level)
  // The stop phase is reached only after all data bits
  `USLM_ASSERT_NOW(a_rx_count, rx_phase == RX_STOP, rx_bit_count == uslm_pkg::RX_DATA_BITS)

endmodule
